/* rtl/core/dq_pkg.sv */
// shared types and constants for the double-ended queue
// no dependencies; imported by every module of the block except dq_ram
package dq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_POP_FRONT  = 2'd1,
        REQ_PUSH_BACK  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_RDWAIT
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic commit;
    } dq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_read;
        logic out_free;
    } dq_sts_t;

endpackage

/* rtl/core/dq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/dq_datapath.sv */
// datapath: request register, ring indices, count, word store and result register
// depends on dq_pkg and dq_ram
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dq_cmd_t                    cmd,
    output dq_sts_t                    sts,
    input  logic [1:0]                 req_type,
    input  logic [DATA_WIDTH-1:0]      value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [DATA_WIDTH-1:0]      popped_value,
    output logic [$clog2(DEPTH+1)-1:0] occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    req_t                  req_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg;
    stat_t                 status_reg, status_next;
    logic [DATA_WIDTH-1:0] popped_reg;
    logic [CNT_W-1:0]      occ_reg;

    logic             is_push, full, empty, ok;
    logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    assign is_push = (req_reg == REQ_PUSH_FRONT) || (req_reg == REQ_PUSH_BACK);
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign ok      = is_push ? !full : !empty;

    // ring wrap for any depth, not only powers of two
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == IDX_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? IDX_LAST : back_reg - 1'b1;

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        wr_addr     = back_reg;
        rd_addr     = front_reg;
        unique case (req_reg)
            REQ_PUSH_FRONT:
            begin
                wr_addr = front_dec;
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_FRONT:
            begin
                rd_addr = front_reg;
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_PUSH_BACK:
            begin
                wr_addr = back_reg;
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    back_next  = back_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                rd_addr = back_dec;
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    back_next  = back_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    assign wr_en = cmd.commit && is_push && !full;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sts.needs_read = !is_push && !empty;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_t'(req_type);
            value_reg <= value;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            popped_reg <= (!is_push && ok) ? rd_data : '0;
            occ_reg    <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign occupancy    = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("stored count above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted push did not raise the count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result shown without a commit");

endmodule

/* rtl/core/dq_ctrl.sv */
// controller: sequences capture, store read and commit for one item at a time
// depends on dq_pkg
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  dq_sts_t sts,
    output dq_cmd_t cmd
);

    fsm_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (sts.needs_read)
                begin
                    state_next = FSM_RDWAIT;
                end
                else if (sts.out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_RDWAIT:
            begin
                if (sts.out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            FSM_EXEC:
            begin
                cmd.rd_en  = sts.needs_read;
                cmd.commit = !sts.needs_read && sts.out_free;
            end
            FSM_RDWAIT:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while result register still held");

    a_read_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> state_reg == FSM_RDWAIT)
        else $error("store read not followed by read wait");

endmodule

/* rtl/core/double_ended_queue.sv */
// double-ended queue top level: ring store with front and back indices
// a push or refused request is captured in idle, then committed to the result register in exec;
// a successful pop reads the registered ram read port in exec and commits in read wait
// a new request is taken only in idle, after the last one commits; out_stall holds off the commit
// reset: indices and count cleared at once; store contents undefined, no clearing pass
// depends on dq_pkg, dq_ctrl, dq_datapath, dq_ram
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic [DATA_WIDTH-1:0]      value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [DATA_WIDTH-1:0]      popped_value,
    output logic [$clog2(DEPTH+1)-1:0] occupancy
);

    dq_cmd_t cmd;
    dq_sts_t sts;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .popped_value (popped_value),
        .occupancy    (occupancy)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue: directed and random requests
// checked against a ring-store predictor; depends on dq_pkg and double_ended_queue
module testbench;
    import dq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int OCC_WIDTH   = $clog2(DEPTH + 1);
    localparam int IDX_WIDTH   = $clog2(DEPTH);
    localparam int RANDOM_REQS = 590;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AFTER  = 150;

    typedef struct {
        req_t                  kind;
        logic [DATA_WIDTH-1:0] word;
    } deque_req_t;

    typedef struct {
        stat_t                 st;
        logic [DATA_WIDTH-1:0] popped;
        logic [OCC_WIDTH-1:0]  occ;
    } deque_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [1:0]            req_type  = REQ_PUSH_FRONT;
    logic [DATA_WIDTH-1:0] value     = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] popped_value;
    logic [OCC_WIDTH-1:0]  occupancy;

    deque_req_t    pending_requests[$];
    deque_result_t expected_results[$];
    deque_req_t    next_req;
    deque_result_t due_result;

    // predictor state
    logic [DATA_WIDTH-1:0] model_words[DEPTH];
    logic [IDX_WIDTH-1:0]  model_front = '0;
    logic [IDX_WIDTH-1:0]  model_back  = '0;
    int                    model_count = 0;

    int requests_sent = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int send_idle_pct;
    int recv_idle_pct;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .popped_value (popped_value),
        .occupancy    (occupancy)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver idles first, then the sender, then neither
    assign send_idle_pct = (requests_sent < 200) ? 12 : (requests_sent < 400) ? 55 : 0;
    assign recv_idle_pct = (results_seen < 200) ? 55 : (results_seen < 400) ? 12 : 0;

    function automatic deque_result_t apply_request(req_t kind, logic [DATA_WIDTH-1:0] word);
        deque_result_t r;
        r.st     = STAT_OK;
        r.popped = '0;
        case (kind) inside
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (model_count == DEPTH)
                    r.st = STAT_FULL;
                else if (kind == REQ_PUSH_FRONT)
                begin
                    model_front              = model_front - 1'b1;
                    model_words[model_front] = word;
                    model_count++;
                end
                else
                begin
                    model_words[model_back] = word;
                    model_back              = model_back + 1'b1;
                    model_count++;
                end
            end
            default:
            begin
                if (model_count == 0)
                    r.st = STAT_EMPTY;
                else if (kind == REQ_POP_FRONT)
                begin
                    r.popped    = model_words[model_front];
                    model_front = model_front + 1'b1;
                    model_count--;
                end
                else
                begin
                    model_back = model_back - 1'b1;
                    r.popped   = model_words[model_back];
                    model_count--;
                end
            end
        endcase
        r.occ = model_count[OCC_WIDTH-1:0];
        return r;
    endfunction

    task automatic queue_request(req_t kind, logic [DATA_WIDTH-1:0] word);
        deque_req_t item;
        item.kind = kind;
        item.word = word;
        pending_requests.push_back(item);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_PUSH_FRONT;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_request(req_t'(req_type), value));
                requests_sent <= requests_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_req.kind;
                    value    <= next_req.word;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result item with no request waiting");
                    error_count++;
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    if (status !== due_result.st)
                    begin
                        $error("status: expected %0d, got %0d", due_result.st, status);
                        error_count++;
                    end
                    if (popped_value !== due_result.popped)
                    begin
                        $error("popped_value: expected %h, got %h",
                               due_result.popped, popped_value);
                        error_count++;
                    end
                    if (occupancy !== due_result.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", due_result.occ, occupancy);
                        error_count++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int made;
        int seg;
        int seg_len;
        int push_bias;
        bit is_push;
        bit at_back;
        req_t kind;
        logic [DATA_WIDTH-1:0] word;

        // directed: empty pops, extreme words, front index wrapping below zero
        queue_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
        queue_request(REQ_POP_BACK, 32'h0000_0000);
        queue_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_request(REQ_PUSH_BACK, 32'h0000_0000);
        queue_request(REQ_PUSH_FRONT, 32'h0000_0001);
        queue_request(REQ_POP_BACK, 32'hA5A5_A5A5);
        queue_request(REQ_POP_BACK, 32'h0000_0000);
        queue_request(REQ_POP_FRONT, 32'h0000_0000);
        queue_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
        queue_request(REQ_PUSH_BACK, 32'h8000_0000);
        queue_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
        queue_request(REQ_POP_FRONT, 32'h0000_0000);
        queue_request(REQ_POP_FRONT, 32'h0000_0000);
        queue_request(REQ_POP_BACK, 32'h0000_0000);

        // random: alternate filling, draining and balanced runs so full and empty recur
        made = 0;
        seg  = 0;
        while (made < RANDOM_REQS)
        begin
            case (seg % 3)
                0:       push_bias = $urandom_range(75, 92);
                1:       push_bias = $urandom_range(8, 25);
                default: push_bias = 50;
            endcase
            seg_len = $urandom_range(20, 45);
            for (int k = 0; k < seg_len && made < RANDOM_REQS; k++)
            begin
                is_push = ($urandom_range(0, 99) < push_bias);
                at_back = 1'($urandom_range(0, 1));
                if (is_push)
                    kind = at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                else
                    kind = at_back ? REQ_POP_BACK : REQ_POP_FRONT;
                case ($urandom_range(0, 15))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                queue_request(kind, word);
                made++;
            end
            seg++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/dq_datapath.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue.sv
sim/testbench.sv
